[rtl/rnp_pkg.sv]
// ----------------------------------------------------------------------------
// rnp_pkg
// Shared types and constants of the ringtone note parser: item structs, the
// note job passed from the parser front to the note back end, the divider
// request and the fixed tone table.
// ----------------------------------------------------------------------------
package rnp_pkg;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
   localparam logic [1:0] STATUS_BPM_ZERO  = 2'd2;

   // shared serial divider sizes
   localparam int DIV_W   = 24;
   localparam int DSR_W   = 12;
   localparam int CNT_W   = 5;

   // highest index of the tone table
   localparam int TONE_LAST = 48;

   typedef struct packed {
      logic [7:0] text_char;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic        is_rest;
      logic [5:0]  note_index;
      logic [11:0] tone_hz;
      logic [11:0] period_ticks;
      logic [10:0] duty_ticks;
      logic [18:0] duration_ms;
      logic [1:0]  status;
   } rsp_type;

   // one parsed note, ready for the arithmetic
   typedef struct packed {
      logic [3:0] semitone;
      logic [3:0] octave;
      logic       dotted;
      logic [9:0] divisor;
      logic [9:0] bpm;
   } job_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DSR_W-1:0]  divisor;
   } div_req_type;

   localparam logic [11:0] TONE_TABLE [0:TONE_LAST] = '{
      12'd0,
      12'd262,  12'd277,  12'd294,  12'd311,  12'd330,  12'd349,
      12'd370,  12'd392,  12'd415,  12'd440,  12'd466,  12'd494,
      12'd523,  12'd554,  12'd587,  12'd622,  12'd659,  12'd698,
      12'd740,  12'd784,  12'd831,  12'd880,  12'd932,  12'd988,
      12'd1047, 12'd1109, 12'd1175, 12'd1245, 12'd1319, 12'd1397,
      12'd1480, 12'd1568, 12'd1661, 12'd1760, 12'd1865, 12'd1976,
      12'd2093, 12'd2217, 12'd2349, 12'd2489, 12'd2637, 12'd2794,
      12'd2960, 12'd3136, 12'd3322, 12'd3520, 12'd3729, 12'd3951
   };

   // tone lookup, zero past the end of the table
   function automatic logic [11:0] tone_lookup(logic [5:0] idx);
      logic [11:0] hz;
      hz = 12'd0;
      if (idx <= 6'(TONE_LAST)) begin
         hz = TONE_TABLE[idx];
      end
      return hz;
   endfunction

endpackage

[rtl/rnp_front.sv]
// ----------------------------------------------------------------------------
// rnp_front
// Character parser: skips the name, reads the d=, o= and b= header fields and
// assembles notes. A finished note leaves as one job per character at most.
// ----------------------------------------------------------------------------
module rnp_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  rnp_pkg::req_type req_in,
   output logic            push,
   output rnp_pkg::job_type job
);

   typedef enum logic [15:0] {
      PH_NAME   = 16'h0001,
      PH_HDR_D  = 16'h0002,
      PH_D_EQ   = 16'h0004,
      PH_D_NUM  = 16'h0008,
      PH_HDR_O  = 16'h0010,
      PH_O_EQ   = 16'h0020,
      PH_O_VAL  = 16'h0040,
      PH_O_SKIP = 16'h0080,
      PH_HDR_B  = 16'h0100,
      PH_B_EQ   = 16'h0200,
      PH_B_NUM  = 16'h0400,
      PH_N_DUR  = 16'h0800,
      PH_N_SHRP = 16'h1000,
      PH_N_DOT  = 16'h2000,
      PH_N_OCT  = 16'h4000,
      PH_N_TAIL = 16'h8000
   } phase_type;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SHARP = 8'h23;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_THREE = 8'h33;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_C     = 8'h63;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_G     = 8'h67;
   localparam logic [7:0] CH_O     = 8'h6F;

   localparam logic [7:0] DEF_DURATION = 8'd4;
   localparam logic [2:0] DEF_OCTAVE   = 3'd6;
   localparam logic [9:0] DEF_BPM      = 10'd63;

   phase_type   phase_ff, phase_in;
   logic [9:0]  acc_ff, acc_in;
   logic [7:0]  defdur_ff, defdur_in;
   logic [2:0]  defoct_ff, defoct_in;
   logic [9:0]  bpm_ff, bpm_in;
   logic [3:0]  semi_ff, semi_in;
   logic        dot_ff, dot_in;
   logic [3:0]  oct_ff, oct_in;

   logic [7:0]  ch;
   logic        is_dig;
   logic        is_comma;
   logic        in_note;
   logic        from_hdr;
   logic        emit;
   logic        taken;
   phase_type   p;
   logic [9:0]  a;
   logic [3:0]  s;
   logic        d;
   logic [3:0]  o;

   // saturating decimal accumulate
   function automatic logic [9:0] add_digit(logic [9:0] acc, logic [3:0] dig);
      logic [13:0] v;
      v = {4'b0, acc} * 14'd10 + {10'b0, dig};
      return (v > 14'd1023) ? 10'h3FF : v[9:0];
   endfunction

   // semitone of a note letter, zero for a pause
   function automatic logic [3:0] letter_code(logic [7:0] c);
      logic [3:0] code;
      case (c)
         CH_C:    code = 4'd1;
         CH_D:    code = 4'd3;
         CH_E:    code = 4'd5;
         CH_F:    code = 4'd6;
         CH_G:    code = 4'd8;
         CH_A:    code = 4'd10;
         CH_B:    code = 4'd12;
         default: code = 4'd0;
      endcase
      return code;
   endfunction

   assign ch       = req_in.text_char;
   assign is_dig   = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_comma = (ch == CH_COMMA);

   // header and note parsing
   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      defdur_in = defdur_ff;
      defoct_in = defoct_ff;
      bpm_in    = bpm_ff;
      semi_in   = semi_ff;
      dot_in    = dot_ff;
      oct_in    = oct_ff;
      in_note   = 1'b0;
      from_hdr  = 1'b0;
      emit      = 1'b0;
      taken     = 1'b0;

      case (phase_ff)
         PH_NAME: begin
            if (ch == CH_COLON) phase_in = PH_HDR_D;
         end
         PH_HDR_D, PH_HDR_O, PH_HDR_B: begin
            if (ch == CH_D && phase_ff == PH_HDR_D) begin
               acc_in   = 10'd0;
               phase_in = PH_D_EQ;
            end else if (ch == CH_O && phase_ff != PH_HDR_B) begin
               phase_in = PH_O_EQ;
            end else if (ch == CH_B) begin
               acc_in   = 10'd0;
               phase_in = PH_B_EQ;
            end else begin
               in_note  = 1'b1;
               from_hdr = 1'b1;
            end
         end
         PH_D_EQ:   phase_in = PH_D_NUM;
         PH_D_NUM: begin
            if (is_dig) begin
               acc_in = add_digit(acc_ff, ch[3:0]);
            end else begin
               if (acc_ff != 10'd0) begin
                  defdur_in = (acc_ff > 10'd255) ? 8'd255 : acc_ff[7:0];
               end
               phase_in = PH_HDR_O;
            end
         end
         PH_O_EQ:   phase_in = PH_O_VAL;
         PH_O_VAL: begin
            if (ch >= CH_THREE && ch <= CH_SEVEN) defoct_in = ch[2:0];
            phase_in = PH_O_SKIP;
         end
         PH_O_SKIP: phase_in = PH_HDR_B;
         PH_B_EQ:   phase_in = PH_B_NUM;
         PH_B_NUM: begin
            if (is_dig) begin
               acc_in = add_digit(acc_ff, ch[3:0]);
            end else begin
               bpm_in   = acc_ff;
               acc_in   = 10'd0;
               semi_in  = 4'd0;
               dot_in   = 1'b0;
               oct_in   = {1'b0, defoct_ff};
               phase_in = PH_N_DUR;
            end
         end
         default:   in_note = 1'b1;
      endcase

      // note fields, fresh when the header ends on this character
      p = from_hdr ? PH_N_DUR : phase_ff;
      a = from_hdr ? 10'd0 : acc_ff;
      s = from_hdr ? 4'd0 : semi_ff;
      d = from_hdr ? 1'b0 : dot_ff;
      o = from_hdr ? {1'b0, defoct_ff} : oct_ff;

      if (p == PH_N_DUR) begin
         if (is_dig) begin
            a = add_digit(a, ch[3:0]);
         end else if (is_comma) begin
            emit = 1'b1;
         end else begin
            s = letter_code(ch);
            p = PH_N_SHRP;
         end
      end else begin
         if (p == PH_N_SHRP) begin
            if (ch == CH_SHARP) begin
               s     = s + 4'd1;
               taken = 1'b1;
            end
            p = PH_N_DOT;
         end
         if (!taken && p == PH_N_DOT) begin
            if (ch == CH_DOT) begin
               d     = 1'b1;
               taken = 1'b1;
            end
            p = PH_N_OCT;
         end
         if (!taken && p == PH_N_OCT) begin
            if (is_dig) begin
               o     = ch[3:0];
               taken = 1'b1;
            end
            p = PH_N_TAIL;
         end
         if (!taken && is_comma) emit = 1'b1;
      end

      if (in_note) begin
         phase_in = p;
         acc_in   = a;
         semi_in  = s;
         dot_in   = d;
         oct_in   = o;
      end

      // a note leaves at a comma or at the end of the string
      push = accept && in_note && (emit || req_in.last_char);

      if (in_note && emit) begin
         acc_in   = 10'd0;
         semi_in  = 4'd0;
         dot_in   = 1'b0;
         oct_in   = {1'b0, defoct_ff};
         phase_in = PH_N_DUR;
      end

      if (req_in.last_char) begin
         phase_in  = PH_NAME;
         acc_in    = 10'd0;
         defdur_in = DEF_DURATION;
         defoct_in = DEF_OCTAVE;
         bpm_in    = DEF_BPM;
         semi_in   = 4'd0;
         dot_in    = 1'b0;
         oct_in    = 4'd0;
      end
   end

   // job built from the note as it stands after this character
   always_comb begin
      job.semitone = s;
      job.octave   = o;
      job.dotted   = d;
      job.divisor  = (a != 10'd0) ? a : {2'b0, defdur_ff};
      job.bpm      = bpm_ff;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_NAME;
         acc_ff    <= 10'd0;
         defdur_ff <= DEF_DURATION;
         defoct_ff <= DEF_OCTAVE;
         bpm_ff    <= DEF_BPM;
         semi_ff   <= 4'd0;
         dot_ff    <= 1'b0;
         oct_ff    <= 4'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         defdur_ff <= defdur_in;
         defoct_ff <= defoct_in;
         bpm_ff    <= bpm_in;
         semi_ff   <= semi_in;
         dot_ff    <= dot_in;
         oct_ff    <= oct_in;
      end
   end

endmodule

[rtl/rnp_queue.sv]
// ----------------------------------------------------------------------------
// rnp_queue
// Two-entry job queue between the parser and the note back end.
// ----------------------------------------------------------------------------
module rnp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rnp_pkg::job_type push_job,
   input  logic             pop,
   output rnp_pkg::job_type head_job,
   output logic             full,
   output logic             empty
);

   rnp_pkg::job_type slot_ff [0:1];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign head_job = slot_ff[rd_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

[rtl/rnp_div.sv]
// ----------------------------------------------------------------------------
// rnp_div
// Restoring radix-2 divider, one quotient bit per cycle, shared by all the
// divisions of a note.
// ----------------------------------------------------------------------------
module rnp_div (
   input  logic                         clock,
   input  logic                         reset,
   input  rnp_pkg::div_req_type         div_req,
   output logic                         done,
   output logic [rnp_pkg::DIV_W-1:0]    quotient
);

   logic [rnp_pkg::DIV_W-1:0] quo_ff, quo_in;
   logic [rnp_pkg::DSR_W-1:0] rem_ff, rem_in;
   logic [rnp_pkg::DSR_W-1:0] dsr_ff;
   logic [rnp_pkg::CNT_W-1:0] cnt_ff;
   logic                      busy_ff;
   logic                      done_ff;
   logic [rnp_pkg::DSR_W:0]   rem_sh;
   logic                      q_bit;
   logic                      last_step;

   assign last_step = (cnt_ff == rnp_pkg::CNT_W'(rnp_pkg::DIV_W - 1));

   // one shift-subtract step
   always_comb begin
      rem_sh = {rem_ff, quo_ff[rnp_pkg::DIV_W-1]};
      q_bit  = (rem_sh >= {1'b0, dsr_ff});
      rem_in = q_bit ? rnp_pkg::DSR_W'(rem_sh - {1'b0, dsr_ff})
                     : rem_sh[rnp_pkg::DSR_W-1:0];
      quo_in = {quo_ff[rnp_pkg::DIV_W-2:0], q_bit};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && last_step;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last_step) busy_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quo_ff <= div_req.dividend;
         rem_ff <= '0;
         dsr_ff <= div_req.divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/rnp_back.sv]
// ----------------------------------------------------------------------------
// rnp_back
// Note back end: takes one job, works out the note length and timer values
// through the shared divider, looks up the tone and holds the result for the output.
// ----------------------------------------------------------------------------
module rnp_back #(
   parameter int TIMER_CLOCK_HZ   = 1000000,
   parameter int NOTE_TABLE_DEPTH = 49
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  rnp_pkg::job_type     head_job,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rnp_pkg::rsp_type     rsp_data
);

   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_BPM  = 5'b00010,
      B_DUR  = 5'b00100,
      B_FREQ = 5'b01000,
      B_OUT  = 5'b10000
   } bstate_type;

   localparam logic [rnp_pkg::DIV_W-1:0] MS_PER_MIN = rnp_pkg::DIV_W'(60000);
   localparam logic [rnp_pkg::DIV_W-1:0] TIMER_DIV  = rnp_pkg::DIV_W'(TIMER_CLOCK_HZ);

   bstate_type             state_ff, state_in;
   rnp_pkg::job_type       job_ff;
   logic                   ok_ff;
   logic [5:0]             idx_ff;
   logic [18:0]            dur_ff;
   logic [11:0]            period_ff;
   logic [10:0]            duty_ff;
   logic                   rsp_valid_ff;
   rnp_pkg::rsp_type       rsp_ff;

   rnp_pkg::div_req_type   div_req;
   logic                   div_done;
   logic [rnp_pkg::DIV_W-1:0] div_q;

   logic [7:0]             oct12;
   logic [7:0]             pos;
   logic                   head_ok;
   logic [5:0]             head_idx;
   logic [11:0]            hz;
   logic [17:0]            dur_q;
   logic                   out_free;

   // table position of the head job
   always_comb begin
      oct12    = {1'b0, head_job.octave, 3'b0} + {2'b0, head_job.octave, 2'b0};
      pos      = oct12 + {4'b0, head_job.semitone};
      head_idx = 6'(pos - 8'd48);
      head_ok  = (head_job.semitone != 4'd0) && (pos >= 8'd49) && (pos <= 8'd96)
                 && (7'(head_idx) < 7'(NOTE_TABLE_DEPTH));
   end

   assign hz       = rnp_pkg::tone_lookup(idx_ff);
   assign dur_q    = div_q[17:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = (state_ff == B_IDLE) && !q_empty;

   // sequencer and divider requests
   always_comb begin
      state_in         = state_ff;
      div_req.start    = 1'b0;
      div_req.dividend = MS_PER_MIN;
      div_req.divisor  = {2'b0, head_job.bpm};
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               if (head_job.bpm != 10'd0) begin
                  div_req.start = 1'b1;
                  state_in      = B_BPM;
               end else if (head_ok) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = TIMER_DIV;
                  div_req.divisor  = rnp_pkg::tone_lookup(head_idx);
                  state_in         = B_FREQ;
               end else begin
                  state_in = B_OUT;
               end
            end
         end
         B_BPM: begin
            div_req.dividend = {6'b0, div_q[15:0], 2'b0};
            div_req.divisor  = {2'b0, job_ff.divisor};
            if (div_done) begin
               div_req.start = 1'b1;
               state_in      = B_DUR;
            end
         end
         B_DUR: begin
            div_req.dividend = TIMER_DIV;
            div_req.divisor  = hz;
            if (div_done) begin
               if (ok_ff) begin
                  div_req.start = 1'b1;
                  state_in      = B_FREQ;
               end else begin
                  state_in = B_OUT;
               end
            end
         end
         B_FREQ: begin
            if (div_done) state_in = B_OUT;
         end
         B_OUT: begin
            if (out_free) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // per-note working registers
   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff    <= head_job;
         ok_ff     <= head_ok;
         idx_ff    <= head_ok ? head_idx : 6'd0;
         dur_ff    <= 19'd0;
         period_ff <= 12'd0;
         duty_ff   <= 11'd0;
      end
      if (state_ff == B_DUR && div_done) begin
         dur_ff <= job_ff.dotted ? ({1'b0, dur_q} + {2'b0, dur_q[17:1]})
                                 : {1'b0, dur_q};
      end
      if (state_ff == B_FREQ && div_done) begin
         period_ff <= (div_q > 24'd4096) ? 12'd4095 : 12'(div_q - 24'd1);
         duty_ff   <= (div_q[rnp_pkg::DIV_W-1:1] > 23'd2047) ? 11'd2047
                                                              : div_q[11:1];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == B_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_OUT && out_free) begin
         rsp_ff.is_rest      <= (job_ff.semitone == 4'd0);
         rsp_ff.note_index   <= idx_ff;
         rsp_ff.tone_hz      <= ok_ff ? hz : 12'd0;
         rsp_ff.period_ticks <= period_ff;
         rsp_ff.duty_ticks   <= duty_ff;
         rsp_ff.duration_ms  <= dur_ff;
         if (job_ff.bpm == 10'd0) begin
            rsp_ff.status <= rnp_pkg::STATUS_BPM_ZERO;
         end else if (job_ff.semitone != 4'd0 && !ok_ff) begin
            rsp_ff.status <= rnp_pkg::STATUS_BAD_INDEX;
         end else begin
            rsp_ff.status <= rnp_pkg::STATUS_OK;
         end
      end
   end

   rnp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/rtttl_note_parser.sv]
// ----------------------------------------------------------------------------
// rtttl_note_parser
// Ringtone text parser: one character per item in, one note result out at
// each comma or at the end of the string.
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_stall | rnp_pkg::req_type
//   rsp_    | out       | rsp_valid/rsp_stall | rnp_pkg::rsp_type
//
// The parser takes one character a cycle while the two-entry note queue has
// room. Each note takes the back end through up to three passes of the
// 24-step serial divider (ms per beat, note length, timer period), fewer for
// a pause, a bad index or a zero bpm. Synchronous reset returns the parser
// to the name field with default header values and empties the queue.
// A stalled result holds in the output register while the back end waits.
// ----------------------------------------------------------------------------
module rtttl_note_parser #(
   parameter int TIMER_CLOCK_HZ   = 1000000,
   parameter int NOTE_TABLE_DEPTH = 49
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rnp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rnp_pkg::rsp_type rsp_data
);

   logic             accept;
   logic             push;
   logic             pop;
   logic             q_full;
   logic             q_empty;
   rnp_pkg::job_type push_job;
   rnp_pkg::job_type head_job;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   rnp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req_in (req_data),
      .push   (push),
      .job    (push_job)
   );

   rnp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   rnp_back #(
      .TIMER_CLOCK_HZ   (TIMER_CLOCK_HZ),
      .NOTE_TABLE_DEPTH (NOTE_TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // zero bpm never carries a length
   a_bpm_zero_no_dur: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == rnp_pkg::STATUS_BPM_ZERO
      |-> rsp_data.duration_ms == 19'd0)
      else $error("zero bpm result with nonzero duration");

   // a pause has no tone
   a_rest_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_rest
      |-> rsp_data.note_index == 6'd0 && rsp_data.tone_hz == 12'd0)
      else $error("pause with tone fields set");

   // a good tone has a table entry
   a_tone_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_rest && rsp_data.status == rnp_pkg::STATUS_OK
      |-> rsp_data.note_index != 6'd0 && rsp_data.tone_hz != 12'd0)
      else $error("tone result without table entry");

endmodule

[dv/tb_rtttl_note_parser.sv]
// ----------------------------------------------------------------------------
// tb_rtttl_note_parser
// Self-checking bench for the ringtone note parser. Characters are driven
// one item at a time; a behavioral copy of the parser predicts each note
// result, and every returned result is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_rtttl_note_parser;

   localparam int TIMER_HZ    = 1000000;
   localparam int TABLE_DEPTH = 49;
   localparam int CYCLE_LIMIT = 1500000;

   // parse phases of the predictor
   typedef enum logic [3:0] {
      P_NAME, P_HDR_D, P_D_EQ, P_D_NUM, P_HDR_O, P_O_EQ, P_O_VAL, P_O_SKIP,
      P_HDR_B, P_B_EQ, P_B_NUM, P_N_DUR, P_N_SHRP, P_N_DOT, P_N_OCT, P_N_TAIL
   } phase_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   rnp_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rnp_pkg::rsp_type rsp_data;

   rtttl_note_parser #(
      .TIMER_CLOCK_HZ  (TIMER_HZ),
      .NOTE_TABLE_DEPTH(TABLE_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #4 clock = ~clock;

   // predictor state
   phase_type   phase;
   int unsigned accum, dflt_dur, dflt_oct, bpm, whole_ms, semi, dotted, octave;

   rnp_pkg::rsp_type notes_due[$];
   int          mismatches = 0;
   int          cycles = 0;
   bit          quiet = 1'b0;

   // note table frequencies
   int unsigned hz_table[0:48] = '{
      0, 262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494,
      523, 554, 587, 622, 659, 698, 740, 784, 831, 880, 932, 988,
      1047, 1109, 1175, 1245, 1319, 1397, 1480, 1568, 1661, 1760, 1865, 1976,
      2093, 2217, 2349, 2489, 2637, 2794, 2960, 3136, 3322, 3520, 3729, 3951};

   function automatic bit is_num(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic int unsigned push_digit(int unsigned a, logic [7:0] c);
      int unsigned v;
      v = a * 10 + (c - "0");
      return v > 1023 ? 1023 : v;
   endfunction

   task automatic parser_clear();
      phase = P_NAME; accum = 0; dflt_dur = 4; dflt_oct = 6; bpm = 63;
      whole_ms = 0; semi = 0; dotted = 0; octave = 0;
   endtask

   task automatic open_note();
      accum = 0; semi = 0; dotted = 0; octave = dflt_oct; phase = P_N_DUR;
   endtask

   task automatic open_melody();
      whole_ms = bpm != 0 ? (60000 / bpm) * 4 : 0;
      open_note();
   endtask

   // finish the current note and queue its result
   task automatic close_note();
      rnp_pkg::rsp_type r;
      int unsigned dv, q;
      int          idx;
      r = '0;
      if (bpm == 0) begin
         r.status = rnp_pkg::STATUS_BPM_ZERO;
      end else begin
         dv = accum != 0 ? accum : dflt_dur;
         if (dv == 0) dv = 1;
         q = whole_ms / dv;
         if (dotted) q += q / 2;
         r.duration_ms = 19'(q);
      end
      if (semi != 0) begin
         idx = (int'(octave) - 4) * 12 + int'(semi);
         if (idx >= 1 && idx <= 48 && idx < TABLE_DEPTH) begin
            q = TIMER_HZ / hz_table[idx];
            r.note_index   = 6'(idx);
            r.tone_hz      = 12'(hz_table[idx]);
            r.period_ticks = 12'((q - 1) > 4095 ? 4095 : q - 1);
            r.duty_ticks   = 11'((q / 2) > 2047 ? 2047 : q / 2);
         end else if (r.status == rnp_pkg::STATUS_OK) begin
            r.status = rnp_pkg::STATUS_BAD_INDEX;
         end
      end
      r.is_rest = semi == 0;
      notes_due.push_back(r);
      open_note();
   endtask

   function automatic int unsigned semitone_of(logic [7:0] c);
      case (c)
         "c": return 1;
         "d": return 3;
         "e": return 5;
         "f": return 6;
         "g": return 8;
         "a": return 10;
         "b": return 12;
         default: return 0;
      endcase
   endfunction

   // one character inside a note; returns 1 when a note was emitted
   task automatic note_step(logic [7:0] c, output bit done);
      done = 0;
      if (phase == P_N_DUR) begin
         if (is_num(c)) accum = push_digit(accum, c);
         else if (c == ",") begin close_note(); done = 1; end
         else begin semi = semitone_of(c); phase = P_N_SHRP; end
         return;
      end
      if (phase == P_N_SHRP) begin
         phase = P_N_DOT;
         if (c == "#") begin semi = (semi + 1) & 15; return; end
      end
      if (phase == P_N_DOT) begin
         phase = P_N_OCT;
         if (c == ".") begin dotted = 1; return; end
      end
      if (phase == P_N_OCT) begin
         phase = P_N_TAIL;
         if (is_num(c)) begin octave = c - "0"; return; end
      end
      if (c == ",") begin close_note(); done = 1; end
   endtask

   // advance the predictor by one accepted item
   task automatic parse_item(rnp_pkg::req_type it);
      logic [7:0] c;
      bit         in_note, done;
      c = it.text_char; in_note = 0; done = 0;
      case (phase)
         P_NAME: if (c == ":") phase = P_HDR_D;
         P_HDR_D, P_HDR_O, P_HDR_B: begin
            if (c == "d" && phase == P_HDR_D) begin accum = 0; phase = P_D_EQ; end
            else if (c == "o" && phase != P_HDR_B) phase = P_O_EQ;
            else if (c == "b") begin accum = 0; phase = P_B_EQ; end
            else begin open_melody(); in_note = 1; note_step(c, done); end
         end
         P_D_EQ: phase = P_D_NUM;
         P_D_NUM: begin
            if (is_num(c)) accum = push_digit(accum, c);
            else begin
               if (accum > 0) dflt_dur = accum > 255 ? 255 : accum;
               phase = P_HDR_O;
            end
         end
         P_O_EQ: phase = P_O_VAL;
         P_O_VAL: begin
            if (c >= "3" && c <= "7") dflt_oct = c - "0";
            phase = P_O_SKIP;
         end
         P_O_SKIP: phase = P_HDR_B;
         P_B_EQ: phase = P_B_NUM;
         P_B_NUM: begin
            if (is_num(c)) accum = push_digit(accum, c);
            else begin bpm = accum; open_melody(); end
         end
         default: begin in_note = 1; note_step(c, done); end
      endcase
      if (it.last_char) begin
         if (in_note && !done) close_note();
         parser_clear();
      end
   endtask

   // result checker
   always @(posedge clock) begin
      rnp_pkg::rsp_type want;
      if (!reset) begin
         cycles <= cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (notes_due.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected note result %p", rsp_data);
            end else begin
               want = notes_due.pop_front();
               if (rsp_data !== want) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("note mismatch: expected %p got %p", want, rsp_data);
               end
            end
         end
      end
   end

   // result-side stall bursts
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (quiet) rsp_stall <= 1'b0;
         else if ($urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            n = $urandom_range(1, 16);
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // timeout guard
   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // send one item, with an optional idle burst first
   task automatic send_char(logic [7:0] c, bit last);
      rnp_pkg::req_type it;
      int      n;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         n = $urandom_range(1, 16);
         repeat (n) @(negedge clock);
      end
      it.text_char = c; it.last_char = last;
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      parse_item(it);
      @(negedge clock);
   endtask

   task automatic send_text(string s, bit end_it);
      for (int i = 0; i < s.len(); i++) send_char(s[i], end_it && i == s.len() - 1);
   endtask

   // directed rows: text, close with last flag, typed result where obvious
   typedef struct {
      string   text;
      bit      ends;
      bit      typed;
      rnp_pkg::rsp_type note;
   } row_type;

   row_type rows[$];
   int      sent;

   function automatic string rand_note();
      string s, letters;
      letters = "cdefgabpx";
      s = "";
      if ($urandom_range(0, 1)) s = $sformatf("%0d", $urandom_range(1, 64));
      s = {s, string'(letters[$urandom_range(0, 8)])};
      if ($urandom_range(0, 2) == 0) s = {s, "#"};
      if ($urandom_range(0, 2) == 0) s = {s, "."};
      if ($urandom_range(0, 1)) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
      if ($urandom_range(0, 9) == 0) s = {s, "zz"};
      return s;
   endfunction

   function automatic string rand_song();
      string s;
      int    k;
      if ($urandom_range(0, 1)) s = "tune:";
      else s = ":";
      if ($urandom_range(0, 3)) s = {s, $sformatf("d=%0d,", $urandom_range(0, 300))};
      if ($urandom_range(0, 3))
         s = {s, "o=", string'(8'("0" + $urandom_range(0, 9))), ","};
      if ($urandom_range(0, 3)) begin
         case ($urandom_range(0, 5))
            0: s = {s, "b=0:"};
            1: s = {s, "b=99999:"};
            default: s = {s, $sformatf("b=%0d:", $urandom_range(1, 400))};
         endcase
      end
      k = $urandom_range(1, 8);
      for (int i = 0; i < k; i++) begin
         s = {s, rand_note()};
         if (i != k - 1) s = {s, ","};
      end
      return s;
   endfunction

   initial begin
      row_type r;
      parser_clear();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults give a quarter rest of 952 ms
      r = '{text: ":p,", ends: 1, typed: 1, note: '0};
      r.note.is_rest = 1; r.note.duration_ms = 19'd952;
      rows.push_back(r);
      r = '{text: "x:b=0:c", ends: 1, typed: 1, note: '0};
      r.note.note_index = 6'd25; r.note.tone_hz = 12'd1047;
      r.note.period_ticks = 12'd954; r.note.duty_ticks = 11'd477;
      r.note.status = rnp_pkg::STATUS_BPM_ZERO;
      rows.push_back(r);
      r = '{text: ":c3", ends: 1, typed: 1, note: '0};
      r.note.duration_ms = 19'd952; r.note.status = rnp_pkg::STATUS_BAD_INDEX;
      rows.push_back(r);
      rows.push_back('{text: ":d=1,o=7,b=1023:b#.9zz,32p#", ends: 1, typed: 0, note: '0});
      rows.push_back('{text: "abc:d=0,o=2,b=250:,1c4,c#4.,16e5,f,g,a,b", ends: 1,
                       typed: 0, note: '0});
      rows.push_back('{text: ":d=9999,b=8:99999c.7,\xf8\x00,\xff#", ends: 1, typed: 0,
                       note: '0});
      rows.push_back('{text: ":o=5,b=1:1d#8,", ends: 1, typed: 0, note: '0});
      rows.push_back('{text: "name:d=8,o", ends: 1, typed: 0, note: '0});

      foreach (rows[i]) begin
         if (rows[i].typed) begin
            send_text(rows[i].text, rows[i].ends);
            if (notes_due.size() != 0) void'(notes_due.pop_back());
            notes_due.push_back(rows[i].note);
         end else begin
            send_text(rows[i].text, rows[i].ends);
         end
      end

      // random songs, occasionally pure noise characters
      sent = 0;
      while (sent < 1950) begin
         string s;
         if (sent > 1700) quiet = 1'b1;
         if ($urandom_range(0, 9) == 0) begin
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            sent++;
         end else begin
            s = rand_song();
            send_text(s, 1);
            sent += s.len();
         end
      end
      req_valid <= 1'b0;

      while (notes_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && notes_due.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
